// ===== hw/rtl/crcfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crcfr_pkg;

	// Longest frame that is accepted, in bytes (valid range 37 to 4094).
	localparam int MAX_FRAME_BYTES = 2048;

	localparam int POS_W = 12;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [POS_W-1:0] MAX_LEN = POS_W'(MAX_FRAME_BYTES);

	// Bytes held back from the CRC: the trailing received CRC.
	localparam logic [POS_W-1:0] CRC_LAG = 12'd4;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [7:0] TYPE_INPUT = 8'h01;
	localparam logic [7:0] TYPE_EMPTY = 8'h02;

	localparam logic [POS_W-1:0] MIN_LEN_INPUT = 12'd37;
	localparam logic [POS_W-1:0] MIN_LEN_BASE  = 12'd21;

	localparam logic [10:0] PLEN_MAX = 11'h7FF;

	typedef enum logic [2:0] {
		STATUS_OK        = 3'd0,
		STATUS_SHORT     = 3'd1,
		STATUS_BAD_MAGIC = 3'd2,
		STATUS_BAD_CRC   = 3'd3,
		STATUS_EMPTY     = 3'd4,
		STATUS_TOO_LONG  = 3'd5
	} status_t;

	// Header and input-report fields taken from their fixed offsets.
	typedef struct packed {
		logic [15:0] magic;
		logic [7:0]  msg_type;
		logic [31:0] seq;
		logic [63:0] time_bits;
		logic [79:0] keys;
		logic [15:0] dx;
		logic [15:0] dy;
		logic [7:0]  buttons;
		logic [7:0]  scroll;
	} frame_cap_t;

	// View of the frame including the byte now on the input.
	typedef struct packed {
		frame_cap_t        cap;
		logic [POS_W-1:0]  len;
		logic              crc_ok;
	} frame_view_t;

	// Reflected CRC-32, one byte.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crcfr_frame_state.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crcfr_frame_state import crcfr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output frame_view_t      view
);

	logic [POS_W-1:0] pos_q;
	logic [31:0]      crc_q;
	logic [7:0]       tail_q [4];
	frame_cap_t       cap_q;

	logic [POS_W-1:0] len;
	logic [31:0]      crc_nxt;
	logic [31:0]      received;
	frame_cap_t       cap_nxt;
	logic [POS_W-1:0] off_seq, off_time, off_keys, off_dx, off_dy;

	assign len      = (pos_q < POS_MAX) ? pos_q + 1'b1 : POS_MAX;
	assign crc_nxt  = (pos_q >= CRC_LAG) ? crc32_byte(crc_q, tail_q[0]) : crc_q;
	assign received = {data_byte, tail_q[3], tail_q[2], tail_q[1]};

	assign off_seq  = pos_q - 12'd5;
	assign off_time = pos_q - 12'd9;
	assign off_keys = pos_q - 12'd17;
	assign off_dx   = pos_q - 12'd27;
	assign off_dy   = pos_q - 12'd29;

	// Drop the current byte into whichever field owns its offset.
	always_comb begin
		cap_nxt = cap_q;
		if (pos_q < 12'd2) begin
			cap_nxt.magic[8*pos_q[0] +: 8] = data_byte;
		end else if (pos_q == 12'd3) begin
			cap_nxt.msg_type = data_byte;
		end else if (pos_q >= 12'd5 && pos_q <= 12'd8) begin
			cap_nxt.seq[8*off_seq[1:0] +: 8] = data_byte;
		end else if (pos_q >= 12'd9 && pos_q <= 12'd16) begin
			cap_nxt.time_bits[8*off_time[2:0] +: 8] = data_byte;
		end else if (pos_q >= 12'd17 && pos_q <= 12'd26) begin
			cap_nxt.keys[8*off_keys[3:0] +: 8] = data_byte;
		end else if (pos_q == 12'd27 || pos_q == 12'd28) begin
			cap_nxt.dx[8*off_dx[0] +: 8] = data_byte;
		end else if (pos_q == 12'd29 || pos_q == 12'd30) begin
			cap_nxt.dy[8*off_dy[0] +: 8] = data_byte;
		end else if (pos_q == 12'd31) begin
			cap_nxt.buttons = data_byte;
		end else if (pos_q == 12'd32) begin
			cap_nxt.scroll = data_byte;
		end
	end

	assign view.cap    = cap_nxt;
	assign view.len    = len;
	assign view.crc_ok = ((crc_nxt ^ CRC_INIT) == received);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
			for (int i = 0; i < 4; i++) tail_q[i] <= '0;
			cap_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
				for (int i = 0; i < 4; i++) tail_q[i] <= '0;
				cap_q <= '0;
			end else begin
				pos_q     <= len;
				crc_q     <= crc_nxt;
				tail_q[0] <= tail_q[1];
				tail_q[1] <= tail_q[2];
				tail_q[2] <= tail_q[3];
				tail_q[3] <= data_byte;
				cap_q     <= cap_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/crc_frame_receiver_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Frame receiver with CRC-32 check and fixed-offset field extraction.
// Input channel: one frame byte per transfer (data_byte), last_byte marks the
// final byte. in_ready is high whenever the result register is empty or is
// being drained in the same cycle, so a byte can be taken every cycle.
// Output channel: one result per frame, presented with out_valid in the cycle
// after the transfer of the last byte; intermediate bytes produce nothing.
// The trailing four bytes of each frame are the received CRC (little-endian)
// and are kept out of the running CRC by a four-byte delay line.
// Throughput: one byte per clock; the byte-wide CRC update and the status
// decision sit between the frame registers and the result register.
// If the receiver stalls, the pending result holds and in_ready drops, so at
// most one finished result waits; bytes stall upstream until it is taken.
// magic_wr_en writes the expected magic word; the user must do so only while idle, which
// the block itself does not enforce. Reset clears the frame position, seeds the CRC with
// all ones, zeroes the captured fields and the magic word, and empties the result register.
module crc_frame_receiver_core import crcfr_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               magic_wr_en,
	input  wire logic [15:0]        magic_wr_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [7:0]              msg_type,
	output logic [31:0]             seq_number,
	output logic [63:0]             timestamp_bits,
	output logic [63:0]             keys_low,
	output logic [15:0]             keys_high,
	output logic signed [15:0]      cursor_dx,
	output logic signed [15:0]      cursor_dy,
	output logic [7:0]              buttons,
	output logic signed [7:0]       scroll,
	output logic [10:0]             payload_length
);

	logic [15:0]  magic_q;
	frame_view_t  view;
	logic         in_xfer;
	status_t      stat_c;
	logic [11:0]  body_len;
	logic [10:0]  plen_c;
	logic [7:0]   min_type;
	logic [11:0]  min_len;
	logic         is_input;
	frame_cap_t   res_c;
	logic [10:0]  plen_sel;

	logic         out_valid_q;
	status_t      status_q;
	frame_cap_t   res_q;
	logic [10:0]  plen_q;

	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	crcfr_frame_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (in_xfer),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.view      (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
		end else if (magic_wr_en) begin
			magic_q <= magic_wr_data;
		end
	end

	// Status checks in priority order; the first that fails wins.
	assign min_type = view.cap.msg_type;
	assign is_input = (min_type == TYPE_INPUT);
	assign min_len  = is_input ? MIN_LEN_INPUT : MIN_LEN_BASE;

	always_comb begin
		if (view.len > MAX_LEN) begin
			stat_c = STATUS_TOO_LONG;
		end else if (view.len < min_len) begin
			stat_c = STATUS_SHORT;
		end else if (view.cap.magic != magic_q) begin
			stat_c = STATUS_BAD_MAGIC;
		end else if (!view.crc_ok) begin
			stat_c = STATUS_BAD_CRC;
		end else if (min_type == TYPE_EMPTY && view.len == MIN_LEN_BASE) begin
			stat_c = STATUS_EMPTY;
		end else begin
			stat_c = STATUS_OK;
		end
	end

	// Payload length only matters on a good frame, where len is at least 21.
	assign body_len = view.len - MIN_LEN_BASE;
	assign plen_c   = (body_len > {1'b0, PLEN_MAX}) ? PLEN_MAX : body_len[10:0];

	// Result payload: failed frames report zeros, non-input types drop the
	// key and mouse fields.
	always_comb begin
		res_c    = '0;
		plen_sel = '0;
		if (stat_c == STATUS_OK) begin
			res_c.msg_type  = view.cap.msg_type;
			res_c.seq       = view.cap.seq;
			res_c.time_bits = view.cap.time_bits;
			plen_sel        = plen_c;
			if (is_input) begin
				res_c.keys    = view.cap.keys;
				res_c.dx      = view.cap.dx;
				res_c.dy      = view.cap.dy;
				res_c.buttons = view.cap.buttons;
				res_c.scroll  = view.cap.scroll;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= STATUS_OK;
			res_q    <= '0;
			plen_q   <= '0;
		end else if (in_xfer && last_byte) begin
			status_q <= stat_c;
			res_q    <= res_c;
			plen_q   <= plen_sel;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign msg_type       = res_q.msg_type;
	assign seq_number     = res_q.seq;
	assign timestamp_bits = res_q.time_bits;
	assign keys_low       = res_q.keys[63:0];
	assign keys_high      = res_q.keys[79:64];
	assign cursor_dx      = res_q.dx;
	assign cursor_dy      = res_q.dy;
	assign buttons        = res_q.buttons;
	assign scroll         = res_q.scroll;
	assign payload_length = plen_q;

`ifndef ASSERT_OFF
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && last_byte |=> out_valid)
		else $error("no result after the last byte of a frame");

	a_frame_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && last_byte |=> view.len == 12'd1)
		else $error("frame position not cleared after the last byte");

	a_failed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> msg_type == 8'd0 && seq_number == 32'd0
		&& payload_length == 11'd0)
		else $error("failed frame carries nonzero fields");

	a_non_input_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && msg_type != TYPE_INPUT |-> keys_low == 64'd0 && buttons == 8'd0)
		else $error("non-input frame carries key or button data");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import crcfr_pkg::*;

	// Generous bound on the whole run; the slowest correct run stays far below it.
	localparam int CYCLE_LIMIT = 1_000_000;
	// Result appears in the cycle after the last byte; the spare cycles cover it.
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_GAP = 14;
	localparam int MISMATCH_PRINT_CAP = 40;
	// Bytes offered over the whole run; random traffic tops up to this count.
	localparam int ITEM_BUDGET = 1150;

	// Frame rules as this bench understands them.
	localparam logic [31:0] CRC32_POLY_REFL = 32'hEDB8_8320;
	localparam logic [7:0] TYPE_PLAIN = 8'h00;
	localparam int INPUT_MIN_LEN = 37;
	localparam int BASE_MIN_LEN = 21;
	localparam logic [11:0] POSITION_CEIL = 12'hFFF;
	localparam logic [11:0] PAYLOAD_CEIL = 12'd2047;

	// How the body bytes of a generated frame are filled.
	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES,
		FILL_EXTREME_LO,
		FILL_EXTREME_HI
	} fill_t;

	// One expected frame report.
	typedef struct {
		status_t     status;
		logic [7:0]  msg_type;
		logic [31:0] seq;
		logic [63:0] stamp;
		logic [63:0] keys_lo;
		logic [15:0] keys_hi;
		logic [15:0] dx;
		logic [15:0] dy;
		logic [7:0]  buttons;
		logic [7:0]  scroll;
		logic [10:0] plen;
	} frame_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic magic_wr_en = 1'b0;
	logic [15:0] magic_wr_data = 16'h0000;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [7:0] msg_type;
	logic [31:0] seq_number;
	logic [63:0] timestamp_bits;
	logic [63:0] keys_low;
	logic [15:0] keys_high;
	logic signed [15:0] cursor_dx;
	logic signed [15:0] cursor_dy;
	logic [7:0] buttons;
	logic signed [7:0] scroll;
	logic [10:0] payload_length;

	// Receiver-side copy of the frame state, advanced on every input transfer.
	logic [15:0] magic_cfg = 16'h0000;
	logic [11:0] rx_pos = '0;
	logic [31:0] rx_crc = '1;
	logic [7:0] rx_tail [4] = '{default: 8'h00};
	logic [15:0] rx_magic = '0;
	logic [7:0] rx_type = '0;
	logic [31:0] rx_seq = '0;
	logic [63:0] rx_stamp = '0;
	logic [79:0] rx_keys = '0;
	logic [15:0] rx_dx = '0;
	logic [15:0] rx_dy = '0;
	logic [7:0] rx_buttons = '0;
	logic [7:0] rx_scroll = '0;

	// Reports of finished frames, oldest first, waiting for their output transfer.
	frame_report_t pending_reports[$];
	frame_report_t due;

	int frames_sent = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int magic_writes = 0;
	int cycle_count = 0;
	int hold_request = 0;
	int status_hits[6] = '{default: 0};
	bit stall_in = 1'b0;
	bit stall_out = 1'b0;

	crc_frame_receiver_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.magic_wr_en(magic_wr_en),
		.magic_wr_data(magic_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.msg_type(msg_type),
		.seq_number(seq_number),
		.timestamp_bits(timestamp_bits),
		.keys_low(keys_low),
		.keys_high(keys_high),
		.cursor_dx(cursor_dx),
		.cursor_dy(cursor_dy),
		.buttons(buttons),
		.scroll(scroll),
		.payload_length(payload_length)
	);

	always #1 clk = ~clk;

	// Reflected CRC-32, fed one bit at a time, least significant bit first.
	function automatic logic [31:0] crc32_shift(input logic [31:0] c, input logic [7:0] b);
		logic fb_bit;
		int k;
		for (k = 0; k < 8; k++) begin
			fb_bit = c[0] ^ b[k];
			c = {1'b0, c[31:1]} ^ (fb_bit ? CRC32_POLY_REFL : 32'd0);
		end
		return c;
	endfunction

	// Advances the receiver copy by one accepted byte. On the last byte of a
	// frame the expected report is queued and the frame state starts over.
	function automatic void advance_receiver(input logic [7:0] b, input logic last);
		int p;
		int min_len;
		logic [11:0] len;
		logic [11:0] body;
		logic [31:0] received;
		status_t st;
		frame_report_t r;
		p = int'(rx_pos);
		len = (rx_pos < POSITION_CEIL) ? rx_pos + 12'd1 : POSITION_CEIL;
		// The oldest byte of the delay line joins the CRC once four bytes are held.
		if (rx_pos >= 12'd4)
			rx_crc = crc32_shift(rx_crc, rx_tail[0]);
		rx_tail[0] = rx_tail[1];
		rx_tail[1] = rx_tail[2];
		rx_tail[2] = rx_tail[3];
		rx_tail[3] = b;
		if (p < 2)
			rx_magic[8*p +: 8] = b;
		else if (p == 3)
			rx_type = b;
		else if (p >= 5 && p <= 8)
			rx_seq[8*(p-5) +: 8] = b;
		else if (p >= 9 && p <= 16)
			rx_stamp[8*(p-9) +: 8] = b;
		else if (p >= 17 && p <= 26)
			rx_keys[8*(p-17) +: 8] = b;
		else if (p == 27 || p == 28)
			rx_dx[8*(p-27) +: 8] = b;
		else if (p == 29 || p == 30)
			rx_dy[8*(p-29) +: 8] = b;
		else if (p == 31)
			rx_buttons = b;
		else if (p == 32)
			rx_scroll = b;
		rx_pos = len;
		if (!last)
			return;

		received = {rx_tail[3], rx_tail[2], rx_tail[1], rx_tail[0]};
		min_len = (rx_type == TYPE_INPUT) ? INPUT_MIN_LEN : BASE_MIN_LEN;
		// The first failing check wins: length limit, minimum length, magic, CRC,
		// then the empty-payload rule for type two.
		if (len > MAX_FRAME_BYTES)
			st = STATUS_TOO_LONG;
		else if (len < min_len)
			st = STATUS_SHORT;
		else if (rx_magic != magic_cfg)
			st = STATUS_BAD_MAGIC;
		else if (~rx_crc != received)
			st = STATUS_BAD_CRC;
		else if (rx_type == TYPE_EMPTY && len == BASE_MIN_LEN)
			st = STATUS_EMPTY;
		else
			st = STATUS_OK;

		// A failed frame reports nothing but its status.
		r.status = st;
		r.msg_type = '0;
		r.seq = '0;
		r.stamp = '0;
		r.keys_lo = '0;
		r.keys_hi = '0;
		r.dx = '0;
		r.dy = '0;
		r.buttons = '0;
		r.scroll = '0;
		r.plen = '0;
		if (st == STATUS_OK) begin
			body = len - 12'(BASE_MIN_LEN);
			r.msg_type = rx_type;
			r.seq = rx_seq;
			r.stamp = rx_stamp;
			r.plen = (body > PAYLOAD_CEIL) ? PAYLOAD_CEIL[10:0] : body[10:0];
			// Only input reports carry keys, mouse and scroll.
			if (rx_type == TYPE_INPUT) begin
				r.keys_lo = rx_keys[63:0];
				r.keys_hi = rx_keys[79:64];
				r.dx = rx_dx;
				r.dy = rx_dy;
				r.buttons = rx_buttons;
				r.scroll = rx_scroll;
			end
		end
		pending_reports.push_back(r);
		status_hits[st]++;

		rx_pos = '0;
		rx_crc = '1;
		rx_tail = '{default: 8'h00};
		rx_magic = '0;
		rx_type = '0;
		rx_seq = '0;
		rx_stamp = '0;
		rx_keys = '0;
		rx_dx = '0;
		rx_dy = '0;
		rx_buttons = '0;
		rx_scroll = '0;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MISMATCH_PRINT_CAP)
			$display("ERROR at result %0d: %s", results_seen, what);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
	endtask

	// Output monitor and input monitor share one process so that a result is
	// always compared before the byte of the same edge can queue a new report.
	// Both sample the values that were stable just before the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("result transfer with no frame waiting");
			end else begin
				due = pending_reports.pop_front();
				check_field("status", status, due.status);
				check_field("msg_type", msg_type, due.msg_type);
				check_field("seq_number", seq_number, due.seq);
				check_field("timestamp_bits", timestamp_bits, due.stamp);
				check_field("keys_low", keys_low, due.keys_lo);
				check_field("keys_high", keys_high, due.keys_hi);
				check_field("cursor_dx", $unsigned(cursor_dx), due.dx);
				check_field("cursor_dy", $unsigned(cursor_dy), due.dy);
				check_field("buttons", buttons, due.buttons);
				check_field("scroll", $unsigned(scroll), due.scroll);
				check_field("payload_length", payload_length, due.plen);
			end
			results_seen++;
		end
		if (arst_n && in_valid && in_ready)
			advance_receiver(data_byte, last_byte);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d reports still outstanding",
				cycle_count, pending_reports.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result receiver. It draws a stall before each transfer when stalling is
	// enabled, and takes a long hold-off whenever the stimulus asks for one,
	// which fills the result register and pushes back on the byte stream.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				out_ready <= 1'b0;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
			end
			stall = stall_out ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offers one byte and returns at the edge where its transfer happens.
	// Valid only drops when an idle gap is drawn, so back-to-back bytes keep
	// valid high without a glitch.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = stall_in ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// Builds a frame of the given length with magic and type in place and a
	// correct trailing CRC, optionally with one flipped bit after the magic and
	// type, and sends it byte by byte. Short frames simply get cut off.
	task automatic send_frame(input int len, input logic [15:0] mg, input logic [7:0] kind,
			input bit bad_crc, input fill_t fill);
		logic [7:0] fb[$];
		logic [31:0] crc;
		int i;
		int idx;
		fb = {};
		for (i = 0; i < len; i++) begin
			case (fill)
				FILL_ZERO: fb.push_back(8'h00);
				FILL_ONES: fb.push_back(8'hFF);
				default:   fb.push_back(8'($urandom));
			endcase
		end
		if (len > 0)
			fb[0] = mg[7:0];
		if (len > 1)
			fb[1] = mg[15:8];
		if (len > 3)
			fb[3] = kind;
		// Most negative and most positive signed values for the mouse and scroll.
		if (fill == FILL_EXTREME_LO && len > 32) begin
			fb[27] = 8'h00;
			fb[28] = 8'h80;
			fb[29] = 8'hFF;
			fb[30] = 8'h7F;
			fb[31] = 8'h01;
			fb[32] = 8'h80;
		end
		if (fill == FILL_EXTREME_HI && len > 32) begin
			fb[27] = 8'hFF;
			fb[28] = 8'h7F;
			fb[29] = 8'h00;
			fb[30] = 8'h80;
			fb[31] = 8'h80;
			fb[32] = 8'h7F;
		end
		if (len >= 4) begin
			crc = '1;
			for (i = 0; i < len - 4; i++)
				crc = crc32_shift(crc, fb[i]);
			crc = ~crc;
			for (i = 0; i < 4; i++)
				fb[len-4+i] = crc[8*i +: 8];
		end
		// A single flipped bit is always caught by CRC-32.
		if (bad_crc && len > 4) begin
			idx = $urandom_range(4, len - 1);
			fb[idx] = fb[idx] ^ (8'h01 << $urandom_range(0, 7));
		end
		for (i = 0; i < len; i++)
			send_byte(fb[i], i == len - 1);
		frames_sent++;
	endtask

	// Stops offering bytes and waits until every queued report has been taken,
	// then waits out a drain period for anything the block might still emit.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The magic word only changes while nothing is in flight.
	task automatic write_magic(input logic [15:0] value);
		wait_idle();
		magic_wr_en <= 1'b1;
		magic_wr_data <= value;
		@(posedge clk);
		magic_wr_en <= 1'b0;
		magic_cfg = value;
		magic_writes++;
	endtask

	// Frames checked against the magic word as it comes out of reset.
	task automatic test_reset_magic();
		stall_in = 1'b1;
		stall_out = 1'b1;
		send_frame(21, 16'h0000, TYPE_PLAIN, 1'b0, FILL_RANDOM);
		send_frame(37, 16'h1234, TYPE_INPUT, 1'b0, FILL_ZERO);
	endtask

	// Lengths right at and next to the minimum for each type, including a
	// single-byte frame and the empty type-two frame.
	task automatic test_min_lengths();
		write_magic(16'hA55A);
		send_frame(36, magic_cfg, TYPE_INPUT, 1'b0, FILL_RANDOM);
		send_frame(37, magic_cfg, TYPE_INPUT, 1'b0, FILL_RANDOM);
		send_frame(20, magic_cfg, TYPE_PLAIN, 1'b0, FILL_RANDOM);
		send_frame(21, magic_cfg, TYPE_PLAIN, 1'b0, FILL_RANDOM);
		send_frame(21, magic_cfg, TYPE_EMPTY, 1'b0, FILL_RANDOM);
		send_frame(22, magic_cfg, TYPE_EMPTY, 1'b0, FILL_RANDOM);
		send_frame(1, magic_cfg, TYPE_PLAIN, 1'b0, FILL_RANDOM);
		send_frame(4, magic_cfg, TYPE_PLAIN, 1'b0, FILL_RANDOM);
	endtask

	// All-ones and signed extremes in every captured field, plus unknown types.
	task automatic test_field_extremes();
		write_magic(16'hFFFF);
		send_frame(40, magic_cfg, TYPE_INPUT, 1'b0, FILL_ONES);
		send_frame(45, magic_cfg, TYPE_INPUT, 1'b0, FILL_EXTREME_LO);
		send_frame(45, magic_cfg, TYPE_INPUT, 1'b0, FILL_EXTREME_HI);
		send_frame(50, magic_cfg, 8'hFF, 1'b0, FILL_RANDOM);
		send_frame(33, magic_cfg, 8'h80, 1'b0, FILL_ZERO);
	endtask

	// Frames with single and combined faults, to confirm which status wins.
	task automatic test_status_order();
		write_magic(16'h0001);
		send_frame(37, 16'h0101, TYPE_INPUT, 1'b0, FILL_RANDOM);
		send_frame(37, magic_cfg, TYPE_INPUT, 1'b1, FILL_RANDOM);
		send_frame(36, 16'h0000, TYPE_INPUT, 1'b1, FILL_RANDOM);
		send_frame(21, magic_cfg, TYPE_EMPTY, 1'b1, FILL_RANDOM);
		send_frame(21, 16'h8001, TYPE_EMPTY, 1'b1, FILL_RANDOM);
	endtask

	// The receiver holds off for a long stretch while short frames stream in
	// back to back, so the result register fills and bytes stall upstream.
	// Afterwards the sender waits until every report is out.
	task automatic test_backpressure();
		int i;
		stall_in = 1'b0;
		stall_out = 1'b0;
		hold_request = 300;
		for (i = 0; i < 8; i++) begin
			if (i % 2 == 0)
				send_frame(25, magic_cfg, TYPE_PLAIN, 1'b0, FILL_RANDOM);
			else
				send_frame(40, magic_cfg, TYPE_INPUT, 1'b0, FILL_RANDOM);
		end
		wait_idle();
	endtask

	// Mostly well-formed frames with random content, the rest broken in one
	// way or another, until the byte budget of the run is used up. The magic
	// word and the idling pattern change every four frames.
	task automatic test_random_traffic();
		int frames;
		int pick;
		int len;
		int r;
		logic [7:0] kind;
		logic [15:0] mg;
		logic [1:0] mode;
		bit bad;
		fill_t fill;
		frames = 0;
		while (bytes_sent < ITEM_BUDGET) begin
			if (frames % 4 == 0) begin
				case ($urandom_range(0, 3))
					0:       mg = 16'h0000;
					1:       mg = 16'hFFFF;
					default: mg = 16'($urandom);
				endcase
				write_magic(mg);
				mode = 2'($urandom_range(0, 3));
				stall_in = mode[0];
				stall_out = mode[1];
			end
			r = $urandom_range(0, 9);
			if (r < 5)
				kind = TYPE_INPUT;
			else if (r < 7)
				kind = TYPE_PLAIN;
			else if (r == 7)
				kind = TYPE_EMPTY;
			else
				kind = 8'($urandom);
			len = (kind == TYPE_INPUT) ? $urandom_range(INPUT_MIN_LEN, 64)
				: $urandom_range(BASE_MIN_LEN, 48);
			if (kind == TYPE_EMPTY && $urandom_range(0, 2) == 0)
				len = BASE_MIN_LEN;
			mg = magic_cfg;
			bad = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick >= 96) begin
				// Pure noise.
				len = $urandom_range(1, 40);
				kind = 8'($urandom);
				mg = 16'($urandom);
				bad = $urandom_range(0, 1);
			end else if (pick >= 88) begin
				len = $urandom_range(1, (kind == TYPE_INPUT) ? INPUT_MIN_LEN - 1
					: BASE_MIN_LEN - 1);
			end else if (pick >= 80) begin
				bad = 1'b1;
			end else if (pick >= 72) begin
				mg = magic_cfg ^ (16'h0001 << $urandom_range(0, 15));
			end
			fill = ($urandom_range(0, 9) == 0) ? fill_t'($urandom_range(1, 4)) : FILL_RANDOM;
			send_frame(len, mg, kind, bad, fill);
			frames++;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_magic();
		test_min_lengths();
		test_field_extremes();
		test_status_order();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		$display("Covered %0d frames (%0d bytes) across %0d magic word writes,",
			frames_sent, bytes_sent, magic_writes);
		$display("outcomes: ok %0d, short %0d, bad magic %0d, bad crc %0d, empty %0d, long %0d",
			status_hits[STATUS_OK], status_hits[STATUS_SHORT],
			status_hits[STATUS_BAD_MAGIC], status_hits[STATUS_BAD_CRC],
			status_hits[STATUS_EMPTY], status_hits[STATUS_TOO_LONG]);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
